// ===== rtl/mmpc_pkg.sv =====
package mmpc_pkg;

    localparam int MAP_SIDE        = 64;
    localparam int TILE_WORLD_SIZE = 64;
    localparam int MAP_DEPTH       = MAP_SIDE * MAP_SIDE;
    localparam int MAP_AW          = $clog2(MAP_DEPTH);
    localparam int PLAYER_RADIUS   = 4;

    // Divider operand widths: an interior offset from the panel centre has a
    // magnitude of at most 1024.
    localparam int DIV_MAG_W = 11;
    localparam int DIV_DEN_W = 7;
    localparam int DIV_Q_W   = 12;
    localparam int DIV_CNT_W = $clog2(DIV_MAG_W);

    localparam logic [2:0] CLS_OUTSIDE    = 3'd0;
    localparam logic [2:0] CLS_BORDER     = 3'd1;
    localparam logic [2:0] CLS_BACKGROUND = 3'd2;
    localparam logic [2:0] CLS_WALL       = 3'd3;
    localparam logic [2:0] CLS_PLAYER     = 3'd6;

    localparam logic [1:0] KIND_OTHER = 2'd0;

    localparam logic REQ_WRITE = 1'b0;

    localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [2:0] REG_PANEL_SIZE   = 3'd2;
    localparam logic [2:0] REG_BORDER_WIDTH = 3'd3;
    localparam logic [2:0] REG_TILE_PX      = 3'd4;
    localparam logic [2:0] REG_VIEW_RAD     = 3'd5;
    localparam logic [2:0] REG_MAP_WIDTH    = 3'd6;
    localparam logic [2:0] REG_MAP_HEIGHT   = 3'd7;

    typedef logic [MAP_AW-1:0] t_map_addr;

endpackage

// ===== rtl/mmpc_ram.sv =====
module mmpc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mmpc_fdiv.sv =====
module mmpc_fdiv (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [mmpc_pkg::DIV_Q_W-1:0]  i_num,
    input  logic [mmpc_pkg::DIV_DEN_W-1:0]       i_den,
    output logic                                 o_done,
    output logic signed [mmpc_pkg::DIV_Q_W-1:0]  o_quot
);

    logic                               r_busy;
    logic                               r_done;
    logic [mmpc_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic                               r_neg;
    logic [mmpc_pkg::DIV_DEN_W-1:0]     r_den;
    logic [mmpc_pkg::DIV_MAG_W-1:0]     r_num;
    logic [mmpc_pkg::DIV_DEN_W-1:0]     r_rem;

    logic [mmpc_pkg::DIV_Q_W-1:0]       w_abs;
    logic [mmpc_pkg::DIV_DEN_W:0]       w_trial;
    logic                               w_ge;
    logic [mmpc_pkg::DIV_DEN_W:0]       w_diff;
    logic [mmpc_pkg::DIV_DEN_W-1:0]     n_rem;
    logic [mmpc_pkg::DIV_Q_W-1:0]       w_qmag;

    assign w_abs   = i_num[mmpc_pkg::DIV_Q_W-1] ? (-i_num) : i_num;
    assign w_trial = {r_rem, r_num[mmpc_pkg::DIV_MAG_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign n_rem   = w_ge ? w_diff[mmpc_pkg::DIV_DEN_W-1:0]
                          : w_trial[mmpc_pkg::DIV_DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == mmpc_pkg::DIV_CNT_W'(mmpc_pkg::DIV_MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[mmpc_pkg::DIV_Q_W-1];
            r_den <= i_den;
            r_num <= w_abs[mmpc_pkg::DIV_MAG_W-1:0];
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[mmpc_pkg::DIV_MAG_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    // Floor division: a negative dividend with a remainder rounds one further down.
    assign w_qmag = {1'b0, r_num} + mmpc_pkg::DIV_Q_W'(r_neg && (r_rem != '0));
    assign o_quot = r_neg ? $signed(-w_qmag) : $signed(w_qmag);
    assign o_done = r_done;

endmodule

// ===== rtl/tile_minimap_pixel_classifier.sv =====
// Minimap pixel classifier. A beat with tuser low writes one 2-bit tile kind
// into the 64 x 64 tile map, gives no result and leaves the block ready for
// the next beat. A beat with tuser high classifies one screen pixel and gives
// one result beat. A pixel that falls outside the panel, in the border band or
// on the player marker, or any pixel while the tile size is zero, is settled in
// the pre-check state; any other pixel goes through two iterative floor
// dividers (one per axis) that retire one quotient bit a cycle, then one tile
// map read. One query is in flight at a time, and a finished result waits in
// the output register while the next beat is accepted. After reset the tile
// map is cleared to zero one entry a cycle, and no beat is accepted until all
// 4096 entries are clear; configuration writes are taken throughout.
module tile_minimap_pixel_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tile_col[5:0], tile_row[11:6], tile_kind[13:12], pixel_x[25:14],
    // pixel_y[37:26], player_x[49:38], player_y[61:50], zero[63:62]
    input  logic [63:0] i_s_axis_tdata,
    // req_type[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel_class[2:0], zero[7:3]
    output logic [7:0]  o_m_axis_tdata
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PRE   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_MAP   = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [mmpc_pkg::MAP_AW-1:0] r_clr_addr;

    logic [11:0] r_origin_x;
    logic [11:0] r_origin_y;
    logic [10:0] r_panel_size;
    logic [7:0]  r_border_width;
    logic [6:0]  r_tile_px;
    logic [5:0]  r_view_rad;
    logic [6:0]  r_map_width;
    logic [6:0]  r_map_height;

    logic [11:0] r_px;
    logic [11:0] r_py;
    logic [11:0] r_plx;
    logic [11:0] r_ply;
    logic [2:0]  r_cls;
    logic [2:0]  n_cls;
    logic        r_hit;
    logic        r_m_valid;
    logic [2:0]  r_m_cls;

    logic        w_accept;
    logic        w_out_free;

    logic [5:0]  w_tile_col;
    logic [5:0]  w_tile_row;
    logic [1:0]  w_tile_kind;
    logic        w_wr_ok;

    logic        w_ram_we;
    mmpc_pkg::t_map_addr w_ram_waddr;
    logic [1:0]  w_ram_wdata;
    mmpc_pkg::t_map_addr w_ram_raddr;
    logic [1:0]  w_ram_rdata;

    logic [12:0] w_xe;
    logic [12:0] w_ye;
    logic        w_outside;
    logic        w_border;
    logic [12:0] w_cx;
    logic [12:0] w_cy;
    logic [13:0] w_dx14;
    logic [13:0] w_dy14;
    logic signed [11:0] w_dx;
    logic signed [11:0] w_dy;
    logic [11:0] w_ax;
    logic [11:0] w_ay;
    logic [5:0]  w_sqx;
    logic [5:0]  w_sqy;
    logic [6:0]  w_sqsum;
    logic        w_player;
    logic        w_div_start;

    logic        w_done_x;
    logic        w_done_y;
    logic signed [11:0] w_col;
    logic signed [11:0] w_row;
    logic signed [12:0] w_rad;
    logic        w_in_rad;
    logic [11:0] w_ptx;
    logic [11:0] w_pty;
    logic signed [13:0] w_mx;
    logic signed [13:0] w_my;
    logic [8:0]  w_mw;
    logic [8:0]  w_mh;
    logic        w_on_map;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    assign w_tile_col  = i_s_axis_tdata[5:0];
    assign w_tile_row  = i_s_axis_tdata[11:6];
    assign w_tile_kind = i_s_axis_tdata[13:12];
    assign w_wr_ok = (32'(w_tile_col) < mmpc_pkg::MAP_SIDE)
                  && (32'(w_tile_row) < mmpc_pkg::MAP_SIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x     <= 12'd0;
            r_origin_y     <= 12'd0;
            r_panel_size   <= 11'd200;
            r_border_width <= 8'd4;
            r_tile_px      <= 7'd10;
            r_view_rad     <= 6'd10;
            r_map_width    <= 7'd0;
            r_map_height   <= 7'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mmpc_pkg::REG_ORIGIN_X:     r_origin_x     <= i_cfg_wdata;
                mmpc_pkg::REG_ORIGIN_Y:     r_origin_y     <= i_cfg_wdata;
                mmpc_pkg::REG_PANEL_SIZE:   r_panel_size   <= i_cfg_wdata[10:0];
                mmpc_pkg::REG_BORDER_WIDTH: r_border_width <= i_cfg_wdata[7:0];
                mmpc_pkg::REG_TILE_PX:      r_tile_px      <= i_cfg_wdata[6:0];
                mmpc_pkg::REG_VIEW_RAD:     r_view_rad     <= i_cfg_wdata[5:0];
                mmpc_pkg::REG_MAP_WIDTH:    r_map_width    <= i_cfg_wdata[6:0];
                mmpc_pkg::REG_MAP_HEIGHT:   r_map_height   <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Panel tests on the registered pixel.
    assign w_xe = {1'b0, r_origin_x} + {2'b0, r_panel_size};
    assign w_ye = {1'b0, r_origin_y} + {2'b0, r_panel_size};
    assign w_outside = (r_px < r_origin_x) || ({1'b0, r_px} >= w_xe)
                    || (r_py < r_origin_y) || ({1'b0, r_py} >= w_ye);
    assign w_border = ({1'b0, r_px} < {1'b0, r_origin_x} + {5'b0, r_border_width})
                   || ({1'b0, r_px} + {5'b0, r_border_width} >= w_xe)
                   || ({1'b0, r_py} < {1'b0, r_origin_y} + {5'b0, r_border_width})
                   || ({1'b0, r_py} + {5'b0, r_border_width} >= w_ye);

    assign w_cx   = {1'b0, r_origin_x} + {3'b0, r_panel_size[10:1]};
    assign w_cy   = {1'b0, r_origin_y} + {3'b0, r_panel_size[10:1]};
    assign w_dx14 = {2'b0, r_px} - {1'b0, w_cx};
    assign w_dy14 = {2'b0, r_py} - {1'b0, w_cy};
    assign w_dx   = $signed(w_dx14[11:0]);
    assign w_dy   = $signed(w_dy14[11:0]);
    assign w_ax   = w_dx[11] ? 12'(-w_dx) : 12'(w_dx);
    assign w_ay   = w_dy[11] ? 12'(-w_dy) : 12'(w_dy);
    assign w_sqx  = {3'b0, w_ax[2:0]} * {3'b0, w_ax[2:0]};
    assign w_sqy  = {3'b0, w_ay[2:0]} * {3'b0, w_ay[2:0]};
    assign w_sqsum = {1'b0, w_sqx} + {1'b0, w_sqy};
    assign w_player = (w_ax <= 12'(mmpc_pkg::PLAYER_RADIUS))
                   && (w_ay <= 12'(mmpc_pkg::PLAYER_RADIUS))
                   && (w_sqsum <= 7'(mmpc_pkg::PLAYER_RADIUS * mmpc_pkg::PLAYER_RADIUS));

    assign w_div_start = (r_state == S_PRE) && !w_outside && !w_border && !w_player
                      && (r_tile_px != 7'd0);

    mmpc_fdiv u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dx),
        .i_den   (r_tile_px),
        .o_done  (w_done_x),
        .o_quot  (w_col)
    );

    mmpc_fdiv u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_dy),
        .i_den   (r_tile_px),
        .o_done  (w_done_y),
        .o_quot  (w_row)
    );

    // Map lookup from the cell offsets.
    assign w_rad    = $signed({7'b0, r_view_rad});
    assign w_in_rad = (13'(w_col) >= -w_rad) && (13'(w_col) <= w_rad)
                   && (13'(w_row) >= -w_rad) && (13'(w_row) <= w_rad);
    assign w_ptx = 12'(r_plx / mmpc_pkg::TILE_WORLD_SIZE);
    assign w_pty = 12'(r_ply / mmpc_pkg::TILE_WORLD_SIZE);
    assign w_mx  = $signed({2'b0, w_ptx}) + 14'(w_col);
    assign w_my  = $signed({2'b0, w_pty}) + 14'(w_row);
    assign w_mw  = (32'(r_map_width) > mmpc_pkg::MAP_SIDE) ? 9'(mmpc_pkg::MAP_SIDE)
                                                           : {2'b0, r_map_width};
    assign w_mh  = (32'(r_map_height) > mmpc_pkg::MAP_SIDE) ? 9'(mmpc_pkg::MAP_SIDE)
                                                            : {2'b0, r_map_height};
    assign w_on_map = (w_mx >= 14'sd0) && (w_mx < $signed({5'b0, w_mw}))
                   && (w_my >= 14'sd0) && (w_my < $signed({5'b0, w_mh}));

    assign w_ram_raddr = mmpc_pkg::t_map_addr'(w_my) * mmpc_pkg::t_map_addr'(mmpc_pkg::MAP_SIDE)
                       + mmpc_pkg::t_map_addr'(w_mx);

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_addr;
            w_ram_wdata = mmpc_pkg::KIND_OTHER;
        end else begin
            w_ram_we    = w_accept && (i_s_axis_tuser == mmpc_pkg::REQ_WRITE) && w_wr_ok;
            w_ram_waddr = mmpc_pkg::t_map_addr'(w_tile_row)
                        * mmpc_pkg::t_map_addr'(mmpc_pkg::MAP_SIDE)
                        + mmpc_pkg::t_map_addr'(w_tile_col);
            w_ram_wdata = w_tile_kind;
        end
    end

    mmpc_ram #(
        .WIDTH (2),
        .DEPTH (mmpc_pkg::MAP_DEPTH)
    ) u_tile_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_cls   = r_cls;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == mmpc_pkg::t_map_addr'(mmpc_pkg::MAP_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept && (i_s_axis_tuser != mmpc_pkg::REQ_WRITE)) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                n_state = S_OUT;
                if (w_outside) begin
                    n_cls = mmpc_pkg::CLS_OUTSIDE;
                end else if (w_border) begin
                    n_cls = mmpc_pkg::CLS_BORDER;
                end else if (w_player) begin
                    n_cls = mmpc_pkg::CLS_PLAYER;
                end else if (r_tile_px == 7'd0) begin
                    n_cls = mmpc_pkg::CLS_BACKGROUND;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_done_x && w_done_y) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_OUT;
                if (!r_hit || (w_ram_rdata == mmpc_pkg::KIND_OTHER)) begin
                    n_cls = mmpc_pkg::CLS_BACKGROUND;
                end else begin
                    n_cls = mmpc_pkg::CLS_WALL + {1'b0, w_ram_rdata} - 3'd1;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px  <= i_s_axis_tdata[25:14];
            r_py  <= i_s_axis_tdata[37:26];
            r_plx <= i_s_axis_tdata[49:38];
            r_ply <= i_s_axis_tdata[61:50];
        end
        r_cls <= n_cls;
        if (r_state == S_MAP) begin
            r_hit <= w_in_rad && w_on_map;
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_m_cls <= r_cls;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {5'b0, r_m_cls};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam logic       REQ_QUERY  = !mmpc_pkg::REQ_WRITE;
    localparam logic [2:0] CLS_DOOR   = 3'd4;
    localparam logic [2:0] CLS_PORTAL = 3'd5;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         LONG_HOLD_CYCLES = 400;

    typedef enum logic [1:0] {TILE_OTHER, TILE_WALL, TILE_DOOR, TILE_PORTAL} t_tile_kind;
    typedef enum {RX_FREE, RX_STALL, RX_RANDOM} t_rx_mode;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [10:0] panel_size;
        logic [7:0]  border_width;
        logic [6:0]  tile_px;
        logic [5:0]  view_rad;
        logic [6:0]  map_width;
        logic [6:0]  map_height;
    } t_minimap_cfg;

    class minimap_scoreboard;
        logic [1:0]   tiles [mmpc_pkg::MAP_DEPTH];
        t_minimap_cfg cfg;
        logic [2:0]   pending_classes [$];
        int           errors;

        function new();
            foreach (tiles[i]) tiles[i] = mmpc_pkg::KIND_OTHER;
            cfg.origin_x     = 12'd0;
            cfg.origin_y     = 12'd0;
            cfg.panel_size   = 11'd200;
            cfg.border_width = 8'd4;
            cfg.tile_px      = 7'd10;
            cfg.view_rad     = 6'd10;
            cfg.map_width    = 7'd0;
            cfg.map_height   = 7'd0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [11:0] val);
            case (idx)
                mmpc_pkg::REG_ORIGIN_X:     cfg.origin_x     = val;
                mmpc_pkg::REG_ORIGIN_Y:     cfg.origin_y     = val;
                mmpc_pkg::REG_PANEL_SIZE:   cfg.panel_size   = val[10:0];
                mmpc_pkg::REG_BORDER_WIDTH: cfg.border_width = val[7:0];
                mmpc_pkg::REG_TILE_PX:      cfg.tile_px      = val[6:0];
                mmpc_pkg::REG_VIEW_RAD:     cfg.view_rad     = val[5:0];
                mmpc_pkg::REG_MAP_WIDTH:    cfg.map_width    = val[6:0];
                mmpc_pkg::REG_MAP_HEIGHT:   cfg.map_height   = val[6:0];
                default: ;
            endcase
        endfunction

        function int floor_quot(int a, int b);
            int q;
            q = a / b;
            if ((a % b != 0) && (a < 0)) q = q - 1;
            return q;
        endfunction

        function logic [2:0] classify_pixel(int px, int py, int plx, int ply);
            int ox, oy, sz, bw, dx, dy, cs, rad, col, row, mx, my, mw, mh;
            ox  = int'(cfg.origin_x);
            oy  = int'(cfg.origin_y);
            sz  = int'(cfg.panel_size);
            bw  = int'(cfg.border_width);
            cs  = int'(cfg.tile_px);
            rad = int'(cfg.view_rad);
            mw  = int'(cfg.map_width);
            mh  = int'(cfg.map_height);
            if (px < ox || px >= ox + sz || py < oy || py >= oy + sz)
                return mmpc_pkg::CLS_OUTSIDE;
            if (px < ox + bw || px >= ox + sz - bw || py < oy + bw || py >= oy + sz - bw)
                return mmpc_pkg::CLS_BORDER;
            dx = px - (ox + sz / 2);
            dy = py - (oy + sz / 2);
            if (dx * dx + dy * dy <= mmpc_pkg::PLAYER_RADIUS * mmpc_pkg::PLAYER_RADIUS)
                return mmpc_pkg::CLS_PLAYER;
            if (cs == 0) return mmpc_pkg::CLS_BACKGROUND;
            col = floor_quot(dx, cs);
            row = floor_quot(dy, cs);
            if (col < -rad || col > rad || row < -rad || row > rad)
                return mmpc_pkg::CLS_BACKGROUND;
            mx = plx / mmpc_pkg::TILE_WORLD_SIZE + col;
            my = ply / mmpc_pkg::TILE_WORLD_SIZE + row;
            if (mw > mmpc_pkg::MAP_SIDE) mw = mmpc_pkg::MAP_SIDE;
            if (mh > mmpc_pkg::MAP_SIDE) mh = mmpc_pkg::MAP_SIDE;
            if (mx < 0 || mx >= mw || my < 0 || my >= mh) return mmpc_pkg::CLS_BACKGROUND;
            case (tiles[my * mmpc_pkg::MAP_SIDE + mx])
                TILE_WALL:   return mmpc_pkg::CLS_WALL;
                TILE_DOOR:   return CLS_DOOR;
                TILE_PORTAL: return CLS_PORTAL;
                default:     return mmpc_pkg::CLS_BACKGROUND;
            endcase
        endfunction

        function void note_input(logic user, logic [63:0] data);
            if (user == mmpc_pkg::REQ_WRITE) begin
                tiles[int'(data[11:6]) * mmpc_pkg::MAP_SIDE + int'(data[5:0])] = data[13:12];
            end else begin
                pending_classes.push_back(classify_pixel(int'(data[25:14]), int'(data[37:26]),
                                                         int'(data[49:38]), int'(data[61:50])));
            end
        endfunction

        function void check_result(logic [2:0] got);
            logic [2:0] want;
            if (pending_classes.size() == 0) begin
                $error("pixel_class: unexpected beat, expected none, actual %0d", got);
                errors++;
            end else begin
                want = pending_classes.pop_front();
                if (got !== want) begin
                    $error("pixel_class: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    minimap_scoreboard board;
    int burst_left;
    int gap_max;
    int hold_requests = 0;
    int holds_served = 0;

    always #10 clk = ~clk;

    tile_minimap_pixel_classifier u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    function automatic int clamp_int(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_minimap_cfg make_cfg(int ox, int oy, int sz, int bw, int cs, int rad,
                                              int mw, int mh);
        t_minimap_cfg c;
        c.origin_x     = 12'(ox);
        c.origin_y     = 12'(oy);
        c.panel_size   = 11'(sz);
        c.border_width = 8'(bw);
        c.tile_px      = 7'(cs);
        c.view_rad     = 6'(rad);
        c.map_width    = 7'(mw);
        c.map_height   = 7'(mh);
        return c;
    endfunction

    function automatic logic [63:0] tile_beat(int col, int row, t_tile_kind kind);
        return {2'b00, 48'd0, kind, 6'(row), 6'(col)};
    endfunction

    function automatic logic [63:0] pixel_beat(int px, int py, int plx, int ply);
        return {2'b00, 12'(ply), 12'(plx), 12'(py), 12'(px), 14'd0};
    endfunction

    function automatic logic [63:0] random_tile_beat(int bx, int by);
        int col, row;
        if ($urandom_range(0, 9) < 7) begin
            col = clamp_int(bx + int'($urandom_range(0, 16)) - 8, 0, mmpc_pkg::MAP_SIDE - 1);
            row = clamp_int(by + int'($urandom_range(0, 16)) - 8, 0, mmpc_pkg::MAP_SIDE - 1);
        end else begin
            col = int'($urandom_range(0, mmpc_pkg::MAP_SIDE - 1));
            row = int'($urandom_range(0, mmpc_pkg::MAP_SIDE - 1));
        end
        return tile_beat(col, row, t_tile_kind'($urandom_range(0, 3)));
    endfunction

    function automatic logic [63:0] random_pixel_beat(int bx, int by);
        int ox, oy, sz, span, px, py, plx, ply, pick;
        ox = int'(board.cfg.origin_x);
        oy = int'(board.cfg.origin_y);
        sz = int'(board.cfg.panel_size);
        pick = int'($urandom_range(0, 9));
        if (pick == 0) begin
            px = int'($urandom_range(0, 4095));
            py = int'($urandom_range(0, 4095));
        end else if (pick < 4) begin
            px = ox - 8 + int'($urandom_range(0, sz + 16));
            py = oy - 8 + int'($urandom_range(0, sz + 16));
        end else begin
            span = int'(board.cfg.tile_px) * 8 + 8;
            px = ox + sz / 2 - span + int'($urandom_range(0, 2 * span));
            py = oy + sz / 2 - span + int'($urandom_range(0, 2 * span));
        end
        if ($urandom_range(0, 9) == 0) begin
            plx = int'($urandom_range(0, 4095));
            ply = int'($urandom_range(0, 4095));
        end else begin
            plx = clamp_int(bx + int'($urandom_range(0, 2)) - 1, 0, mmpc_pkg::MAP_SIDE - 1)
                  * mmpc_pkg::TILE_WORLD_SIZE
                  + int'($urandom_range(0, mmpc_pkg::TILE_WORLD_SIZE - 1));
            ply = clamp_int(by + int'($urandom_range(0, 2)) - 1, 0, mmpc_pkg::MAP_SIDE - 1)
                  * mmpc_pkg::TILE_WORLD_SIZE
                  + int'($urandom_range(0, mmpc_pkg::TILE_WORLD_SIZE - 1));
        end
        return pixel_beat(clamp_int(px, 0, 4095), clamp_int(py, 0, 4095), plx, ply);
    endfunction

    task automatic apply_config(input t_minimap_cfg c);
        logic [11:0] vals [8];
        vals[mmpc_pkg::REG_ORIGIN_X]     = c.origin_x;
        vals[mmpc_pkg::REG_ORIGIN_Y]     = c.origin_y;
        vals[mmpc_pkg::REG_PANEL_SIZE]   = 12'(c.panel_size);
        vals[mmpc_pkg::REG_BORDER_WIDTH] = 12'(c.border_width);
        vals[mmpc_pkg::REG_TILE_PX]      = 12'(c.tile_px);
        vals[mmpc_pkg::REG_VIEW_RAD]     = 12'(c.view_rad);
        vals[mmpc_pkg::REG_MAP_WIDTH]    = 12'(c.map_width);
        vals[mmpc_pkg::REG_MAP_HEIGHT]   = 12'(c.map_height);
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge clk);
            board.set_reg(3'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input logic user, input logic [63:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_input(user, data);
        if (gap_max > 0 && burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_classes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input t_minimap_cfg c, input int n_items, input int gap_limit,
                                input bit long_hold);
        int bx, by;
        bx = int'($urandom_range(0, mmpc_pkg::MAP_SIDE - 1));
        by = int'($urandom_range(0, mmpc_pkg::MAP_SIDE - 1));
        apply_config(c);
        gap_max = gap_limit;
        burst_left = 0;
        if (long_hold) hold_requests <= hold_requests + 1;
        repeat (n_items) begin
            if ($urandom_range(0, 9) < 3) begin
                send_beat(mmpc_pkg::REQ_WRITE, random_tile_beat(bx, by));
            end else begin
                send_beat(REQ_QUERY, random_pixel_beat(bx, by));
            end
        end
        drain();
    endtask

    // The receiver runs its own pattern of free, stalled and random stretches, and
    // holds off for a long stretch whenever the stimulus asks for it.
    initial begin : result_sink
        t_rx_mode mode;
        int       seg_len;
        @(posedge clk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else begin
                mode = t_rx_mode'($urandom_range(0, 2));
                seg_len = $urandom_range(1, 40);
                repeat (seg_len) begin
                    case (mode)
                        RX_FREE:  m_tready <= 1'b1;
                        RX_STALL: m_tready <= 1'b0;
                        default:  m_tready <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            board.check_result(m_tdata[2:0]);
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        t_minimap_cfg c;
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        apply_config(make_cfg(100, 60, 200, 4, 10, 10, 64, 64));
        gap_max = 2;
        burst_left = 0;
        send_beat(mmpc_pkg::REQ_WRITE, tile_beat(11, 10, TILE_WALL));
        send_beat(mmpc_pkg::REQ_WRITE, tile_beat(10, 11, TILE_DOOR));
        send_beat(mmpc_pkg::REQ_WRITE, tile_beat(9, 10, TILE_PORTAL));
        send_beat(mmpc_pkg::REQ_WRITE, tile_beat(0, 0, TILE_PORTAL));
        send_beat(mmpc_pkg::REQ_WRITE, tile_beat(63, 63, TILE_WALL));
        send_beat(REQ_QUERY, pixel_beat(99, 160, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(300, 160, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(200, 59, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(200, 260, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(0, 0, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(4095, 4095, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(100, 160, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(296, 255, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(200, 160, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(204, 160, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(203, 163, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(215, 165, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(205, 175, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(195, 165, 640, 640));
        send_beat(REQ_QUERY, pixel_beat(205, 165, 63, 63));
        send_beat(REQ_QUERY, pixel_beat(195, 165, 63, 63));
        send_beat(REQ_QUERY, pixel_beat(205, 165, 4095, 4095));
        send_beat(REQ_QUERY, pixel_beat(215, 165, 4095, 4095));
        drain();

        random_phase(make_cfg(0, 0, 200, 4, 10, 10, 64, 64), 100, 6, 1'b0);
        random_phase(make_cfg(1000, 2000, 1024, 0, 1, 63, 64, 64), 100, 0, 1'b1);
        random_phase(make_cfg(300, 10, 300, 2, 0, 5, 64, 64), 60, 4, 1'b0);
        random_phase(make_cfg(20, 20, 100, 60, 10, 10, 64, 64), 50, 3, 1'b0);
        random_phase(make_cfg(0, 0, 1024, 16, 64, 63, 127, 127), 100, 5, 1'b0);
        random_phase(make_cfg(4095, 4095, 1024, 255, 64, 63, 0, 0), 30, 2, 1'b0);
        random_phase(make_cfg(500, 500, 0, 0, 1, 0, 64, 64), 30, 0, 1'b0);
        random_phase(make_cfg(3071, 3071, 1024, 0, 3, 0, 20, 30), 80, 4, 1'b0);
        repeat (4) begin
            c = make_cfg($urandom_range(0, 3500), $urandom_range(0, 3500),
                         $urandom_range(0, 1024),
                         ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 40),
                         $urandom_range(0, 64), $urandom_range(0, 63),
                         $urandom_range(0, 64), $urandom_range(0, 64));
            random_phase(c, 90, $urandom_range(0, 6), 1'b0);
        end

        if (board.errors == 0 && board.pending_classes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mmpc_pkg.sv
rtl/mmpc_ram.sv
rtl/mmpc_fdiv.sv
rtl/tile_minimap_pixel_classifier.sv
verif/tb_top.sv
